@@ rtl/bilinear_pixel_sampler_macros.svh @@
// assertion macros for the bilinear pixel sampler checker
// no dependencies
`ifndef BILINEAR_PIXEL_SAMPLER_MACROS_SVH
`define BILINEAR_PIXEL_SAMPLER_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define BPS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bps check failed");
// next-cycle implication checked outside reset
`define BPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bps check failed");
`endif

@@ rtl/bps_pkg.sv @@
// shared types, constants and helpers for the bilinear pixel sampler
// no dependencies
package bps_pkg;
   localparam int MAX_COLS = 512;
   localparam int MAX_ROWS = 512;
   localparam int FRAC_BITS = 8;
   localparam int COL_BITS = $clog2(MAX_COLS);
   localparam int ROW_BITS = $clog2(MAX_ROWS);
   localparam int CFG_BITS = 10;
   localparam int PT_BITS = 20;
   localparam int INT_BITS = PT_BITS - FRAC_BITS;
   // signed fraction -(S-1)..S-1, weights -(S-1)..2S-1
   localparam int FR_BITS = FRAC_BITS + 1;
   localparam int W_BITS = FRAC_BITS + 2;
   localparam int BANK_COLS = MAX_COLS / 2;
   localparam int BANK_ROWS = MAX_ROWS / 2;
   localparam int BANK_DEPTH = BANK_COLS * BANK_ROWS;
   localparam int BADDR_BITS = $clog2(BANK_DEPTH);
   localparam int HC_BITS = $clog2(BANK_COLS);
   localparam int HR_BITS = $clog2(BANK_ROWS);
   // blend sums: top in S-units times weight, total up to 255*S*S*9
   localparam int TOP_BITS = 8 + W_BITS + 2;
   localparam int TOT_BITS = TOP_BITS + W_BITS + 2;

   localparam logic [CFG_BITS-1:0] REG_COLS = CFG_BITS'(0);
   localparam logic [CFG_BITS-1:0] REG_ROWS = CFG_BITS'(1);

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   typedef struct packed {
      logic [HR_BITS-1:0] hrow;
      logic [HC_BITS-1:0] hcol;
   } bank_addr_type;

   // reflect-101 of an integer index into 0..n-1, ok flag in the top bit
   function automatic logic [COL_BITS:0] mirror101(logic signed [INT_BITS+1:0] p,
                                                   logic [CFG_BITS:0] n);
      logic signed [INT_BITS+2:0] len;
      logic signed [INT_BITS+2:0] span;
      logic signed [INT_BITS+2:0] q;
      logic ok;
      len = (INT_BITS+3)'($signed({1'b0, n}));
      span = len + len - (INT_BITS+3)'(2);
      q = (INT_BITS+3)'(p);
      ok = 1'b1;
      if (n == (CFG_BITS+1)'(1)) begin
         q = '0;
      end else if (q < 0) begin
         if (q < -(len - (INT_BITS+3)'(1))) ok = 1'b0;
         q = -q;
      end else if (q >= len) begin
         if (q > span) ok = 1'b0;
         q = span - q;
      end
      return {ok, q[COL_BITS-1:0]};
   endfunction
endpackage

@@ rtl/bps_if.sv @@
// valid/ready channel interfaces for the bilinear pixel sampler
// depends on bps_pkg
interface bps_req_if import bps_pkg::*; ();
   logic valid;
   logic ready;
   logic cmd;
   logic [COL_BITS-1:0] pixel_col;
   logic [ROW_BITS-1:0] pixel_row;
   logic [7:0] pixel_value;
   logic signed [PT_BITS-1:0] point_x;
   logic signed [PT_BITS-1:0] point_y;
   modport source (output valid, cmd, pixel_col, pixel_row, pixel_value, point_x, point_y,
                   input ready);
   modport sink (input valid, cmd, pixel_col, pixel_row, pixel_value, point_x, point_y,
                 output ready);
endinterface

interface bps_rsp_if ();
   logic valid;
   logic ready;
   logic [7:0] sample_value;
   logic out_of_range;
   modport source (output valid, sample_value, out_of_range, input ready);
   modport sink (input valid, sample_value, out_of_range, output ready);
endinterface

@@ rtl/bps_bank.sv @@
// one parity bank of the image store, one write and one registered read port
// depends on bps_pkg
module bps_bank import bps_pkg::*; (
   input  logic                  clock,
   input  logic                  en,
   input  logic                  wr_en,
   input  logic [BADDR_BITS-1:0] wr_addr,
   input  logic [7:0]            wr_data,
   input  logic [BADDR_BITS-1:0] rd_addr,
   output logic [7:0]            rd_data
);
   logic [7:0] mem [BANK_DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (en) rd_data <= mem[rd_addr];
   end
endmodule

@@ rtl/bilinear_pixel_sampler.sv @@
// channel   | dir | beat contents
// req_      | in  | cmd, pixel_col/row/value, point_x/y
// rsp_      | out | sample_value, out_of_range
// csr_      | in  | image_cols (0), image_rows (1)
// one beat per cycle unless rsp stalls; a sample passes the s1, s2, s3 and output regs
// the four parity banks give all neighbors in one read, blend along x then along y
// a write beat makes no result; a write and a later sample are ordered by the bank port
// stall freezes the whole pipe; reset is synchronous, clears valids, sets sizes to max
// depends on bps_pkg, bps_if, bps_bank
module bilinear_pixel_sampler import bps_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   bps_req_if.sink             req,
   bps_rsp_if.source           rsp,
   input  logic                csr_we,
   input  logic [CFG_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0] csr_data
);
   logic [CFG_BITS-1:0] cols_ff, rows_ff;
   logic adv;
   logic s1_v_ff, s2_v_ff, s3_v_ff, o_v_ff;
   assign adv = !o_v_ff || rsp.ready;
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= CFG_BITS'(MAX_COLS);
         rows_ff <= CFG_BITS'(MAX_ROWS);
      end else if (csr_we) begin
         if (csr_index == REG_COLS) cols_ff <= csr_data;
         else if (csr_index == REG_ROWS) rows_ff <= csr_data;
      end
   end

   logic [CFG_BITS:0] ncols, nrows;
   always_comb begin
      ncols = {1'b0, cols_ff};
      nrows = {1'b0, rows_ff};
      if (cols_ff == '0) ncols = (CFG_BITS+1)'(1);
      else if (cols_ff > CFG_BITS'(MAX_COLS)) ncols = (CFG_BITS+1)'(MAX_COLS);
      if (rows_ff == '0) nrows = (CFG_BITS+1)'(1);
      else if (rows_ff > CFG_BITS'(MAX_ROWS)) nrows = (CFG_BITS+1)'(MAX_ROWS);
   end

   // stage 0: truncate toward zero, mirror the four indices
   logic acc;
   logic signed [INT_BITS-1:0] xi, yi;
   logic signed [FR_BITS-1:0] fa, fc;
   logic [COL_BITS:0] mx0, mx1, my0, my1;
   assign acc = req.valid && adv;
   always_comb begin
      logic signed [PT_BITS-1:0] ax, ay;
      ax = req.point_x;
      ay = req.point_y;
      xi = ax[PT_BITS-1:FRAC_BITS];
      yi = ay[PT_BITS-1:FRAC_BITS];
      if (ax < 0 && ax[FRAC_BITS-1:0] != '0) xi = xi + INT_BITS'(1);
      if (ay < 0 && ay[FRAC_BITS-1:0] != '0) yi = yi + INT_BITS'(1);
      fa = FR_BITS'(ax - PT_BITS'({xi, {FRAC_BITS{1'b0}}}));
      fc = FR_BITS'(ay - PT_BITS'({yi, {FRAC_BITS{1'b0}}}));
      mx0 = mirror101((INT_BITS+2)'(xi), ncols);
      mx1 = mirror101((INT_BITS+2)'(xi) + (INT_BITS+2)'(1), ncols);
      my0 = mirror101((INT_BITS+2)'(yi), nrows);
      my1 = mirror101((INT_BITS+2)'(yi) + (INT_BITS+2)'(1), nrows);
   end

   // bank k = {row parity, col parity}; each bank holds one neighbor
   logic [BADDR_BITS-1:0] rd_addr [4];
   logic [1:0] sel_in;  // bank of (y0,x0)
   logic [7:0] bank_q [4];
   logic wr_hit;
   logic [1:0] wr_bank;
   logic [BADDR_BITS-1:0] wr_addr;
   assign wr_hit = acc && req.cmd == CMD_WRITE;
   assign wr_bank = {req.pixel_row[0], req.pixel_col[0]};
   assign wr_addr = {req.pixel_row[ROW_BITS-1:1], req.pixel_col[COL_BITS-1:1]};
   assign sel_in = {my0[0], mx0[0]};

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         logic [COL_BITS-1:0] cx;
         logic [ROW_BITS-1:0] ry;
         cx = (k[0] == mx0[0]) ? mx0[COL_BITS-1:0] : mx1[COL_BITS-1:0];
         ry = (k[1] == my0[0]) ? ROW_BITS'(my0[COL_BITS-1:0]) : ROW_BITS'(my1[COL_BITS-1:0]);
         rd_addr[k] = {ry[ROW_BITS-1:1], cx[COL_BITS-1:1]};
      end
   end

   for (genvar k = 0; k < 4; k++) begin : g_bank
      bps_bank u_bank (
         .clock   (clock),
         .en      (adv),
         .wr_en   (wr_hit && wr_bank == 2'(k)),
         .wr_addr (wr_addr),
         .wr_data (req.pixel_value),
         .rd_addr (rd_addr[k]),
         .rd_data (bank_q[k])
      );
   end

   // when x0 == x1 or y0 == y1 the mirrored pair shares a bank; the mux below
   // picks the right bank per neighbor from the parities
   logic [1:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic s1_oor_ff;
   logic signed [FR_BITS-1:0] a1_ff, c1_ff;
   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else if (adv) s1_v_ff <= acc && req.cmd == CMD_SAMPLE;
      if (adv) begin
         p00_ff <= sel_in;
         p01_ff <= {my0[0], mx1[0]};
         p10_ff <= {my1[0], mx0[0]};
         p11_ff <= {my1[0], mx1[0]};
         s1_oor_ff <= !(mx0[COL_BITS] && mx1[COL_BITS] && my0[COL_BITS] && my1[COL_BITS]);
         a1_ff <= fa;
         c1_ff <= fc;
      end
   end

   // stage 2: horizontal blend
   logic signed [W_BITS-1:0] wa0, wa1;
   assign wa1 = W_BITS'(a1_ff);
   assign wa0 = W_BITS'(1 << FRAC_BITS) - wa1;
   logic signed [TOP_BITS-1:0] top_ff, bot_ff;
   logic signed [FR_BITS-1:0] c2_ff;
   logic s2_oor_ff;
   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else if (adv) s2_v_ff <= s1_v_ff;
      if (adv) begin
         top_ff <= TOP_BITS'($signed({1'b0, bank_q[p00_ff]}) * wa0
                  + $signed({1'b0, bank_q[p01_ff]}) * wa1);
         bot_ff <= TOP_BITS'($signed({1'b0, bank_q[p10_ff]}) * wa0
                  + $signed({1'b0, bank_q[p11_ff]}) * wa1);
         c2_ff <= c1_ff;
         s2_oor_ff <= s1_oor_ff;
      end
   end

   // stage 3: vertical blend
   logic signed [W_BITS-1:0] wc0, wc1;
   assign wc1 = W_BITS'(c2_ff);
   assign wc0 = W_BITS'(1 << FRAC_BITS) - wc1;
   logic signed [TOT_BITS-1:0] tot_ff;
   logic s3_oor_ff;
   always_ff @(posedge clock) begin
      if (reset) s3_v_ff <= 1'b0;
      else if (adv) s3_v_ff <= s2_v_ff;
      if (adv) begin
         tot_ff <= TOT_BITS'(top_ff * wc0) + TOT_BITS'(bot_ff * wc1);
         s3_oor_ff <= s2_oor_ff;
      end
   end

   // round half to even, saturate, zero when out of range
   logic [7:0] res;
   always_comb begin
      logic [TOT_BITS-1:0] q;
      logic [2*FRAC_BITS-1:0] r;
      q = TOT_BITS'(tot_ff >>> (2 * FRAC_BITS));
      r = tot_ff[2*FRAC_BITS-1:0];
      if (r > (2*FRAC_BITS)'(1 << (2*FRAC_BITS-1))
          || (r == (2*FRAC_BITS)'(1 << (2*FRAC_BITS-1)) && q[0]))
         q = q + TOT_BITS'(1);
      if (tot_ff <= 0 || s3_oor_ff) res = '0;
      else if (q > TOT_BITS'(255)) res = 8'hff;
      else res = q[7:0];
   end

   logic [7:0] val_ff;
   logic oor_ff;
   always_ff @(posedge clock) begin
      if (reset) o_v_ff <= 1'b0;
      else if (adv) o_v_ff <= s3_v_ff;
      if (adv) begin
         val_ff <= res;
         oor_ff <= s3_oor_ff;
      end
   end
   assign rsp.valid = o_v_ff;
   assign rsp.sample_value = val_ff;
   assign rsp.out_of_range = oor_ff;
endmodule

@@ rtl/bps_checker.sv @@
// port-level checks for the bilinear pixel sampler, bound to the top level
// depends on bps_pkg and the assertion macros header
`include "bilinear_pixel_sampler_macros.svh"
module bps_checker import bps_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [7:0] sample_value,
   input logic out_of_range
);
   `BPS_ASSERT_IMPL(a_oor_zero, clock, reset, rsp_valid && out_of_range, sample_value == 8'd0)
   `BPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(sample_value))
   `BPS_ASSERT_IMPL(a_ready_free, clock, reset, !rsp_valid, req_ready)
   `BPS_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)
endmodule

bind bilinear_pixel_sampler bps_checker u_bps_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .sample_value(rsp.sample_value), .out_of_range(rsp.out_of_range)
);
